/* src/rsa_pkg.sv */
// ----------------------------------------------------------------------------
// rsa_pkg
// Shared sizes, operation and status codes, and the controller command bundle
// for the reference-counted slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package rsa_pkg;

	localparam int SLOT_COUNT  = 64;
	localparam int VALUE_WIDTH = 64;
	localparam int COUNT_WIDTH = 8;

	localparam int IDX_W = $clog2(SLOT_COUNT);
	localparam int LEN_W = $clog2(SLOT_COUNT + 1);

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
	localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_READ  = 2'd1,
		OP_ADD   = 2'd2,
		OP_DROP  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK   = 3'd0,
		ST_FULL = 3'd1,
		ST_OOB  = 3'd2,
		ST_UAF  = 3'd3,
		ST_OVF  = 3'd4
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	typedef struct packed {
		logic accept;
		logic exec;
	} ctrl_cmd_t;

endpackage

`default_nettype wire

/* src/refcounted_slot_allocator.sv */
// A request taken at a clock edge is executed in the EXEC state, and its
// result is registered onto the outputs, with done high for one cycle.
// No new request is taken while busy is high in that state; the count
// read-modify-write through the registered memory read port needs it.
// Results cannot be stalled. Reset clears the live-slot vector and the pool
// length, so all counts read zero; neither memory is cleared or needs it.
// ----------------------------------------------------------------------------
// refcounted_slot_allocator
// Pool of value slots with per-slot reference counts: allocate, read,
// add reference and drop reference, with status codes for each request.
// ----------------------------------------------------------------------------
`default_nettype none

module refcounted_slot_allocator (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire logic [1:0]                           opcode,
	input  wire logic [rsa_pkg::IDX_W-1:0]            slot_index,
	input  wire logic [rsa_pkg::VALUE_WIDTH-1:0]      store_value,
	output logic                                      done,
	output rsa_pkg::status_t                          status,
	output logic      [rsa_pkg::IDX_W-1:0]            granted_slot,
	output logic      [rsa_pkg::VALUE_WIDTH-1:0]      read_value,
	output logic      [rsa_pkg::LEN_W-1:0]            live_length,
	output logic      [rsa_pkg::COUNT_WIDTH-1:0]      slot_count
);
	import rsa_pkg::*;

	ctrl_cmd_t cmd;

	rsa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	rsa_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.opcode       (opcode),
		.slot_index   (slot_index),
		.store_value  (store_value),
		.done         (done),
		.status       (status),
		.granted_slot (granted_slot),
		.read_value   (read_value),
		.live_length  (live_length),
		.slot_count   (slot_count)
	);

endmodule

`default_nettype wire

/* src/rsa_ram.sv */
// ----------------------------------------------------------------------------
// rsa_ram
// Generic memory with one write port and one read port; read data is
// registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* src/rsa_ctrl.sv */
// ----------------------------------------------------------------------------
// rsa_ctrl
// Two-state controller: takes a request, then executes it once the stored
// slot data has been read.
// ----------------------------------------------------------------------------
`default_nettype none

module rsa_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	output rsa_pkg::ctrl_cmd_t      cmd
);
	import rsa_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		busy       = 1'b0;
		cmd.accept = 1'b0;
		cmd.exec   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					state_d    = S_EXEC;
				end
			end
			S_EXEC: begin
				busy     = 1'b1;
				cmd.exec = 1'b1;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

/* src/rsa_dp.sv */
// ----------------------------------------------------------------------------
// rsa_dp
// Datapath: value and count memories, live-slot vector, pool length, the
// free-slot and last-live priority encoders, and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module rsa_dp (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire rsa_pkg::ctrl_cmd_t                   cmd,
	input  wire logic [1:0]                           opcode,
	input  wire logic [rsa_pkg::IDX_W-1:0]            slot_index,
	input  wire logic [rsa_pkg::VALUE_WIDTH-1:0]      store_value,
	output logic                                      done,
	output rsa_pkg::status_t                          status,
	output logic      [rsa_pkg::IDX_W-1:0]            granted_slot,
	output logic      [rsa_pkg::VALUE_WIDTH-1:0]      read_value,
	output logic      [rsa_pkg::LEN_W-1:0]            live_length,
	output logic      [rsa_pkg::COUNT_WIDTH-1:0]      slot_count
);
	import rsa_pkg::*;

	op_t                    op_q;
	logic [IDX_W-1:0]       idx_q;
	logic [VALUE_WIDTH-1:0] val_q;

	logic [SLOT_COUNT-1:0]  live_q;
	logic [LEN_W-1:0]       length_q;
	logic                   done_q;

	logic [VALUE_WIDTH-1:0] val_rd;
	logic [COUNT_WIDTH-1:0] cnt_rd;
	logic [COUNT_WIDTH-1:0] cnt_cur;

	logic [SLOT_COUNT-1:0]  free_vec;
	logic                   free_found;
	logic [IDX_W-1:0]       free_idx;
	logic [SLOT_COUNT-1:0]  live_drop;
	logic                   hi_found;
	logic [IDX_W-1:0]       hi_idx;

	logic                   val_we;
	logic                   cnt_we;
	logic [IDX_W-1:0]       wr_idx;
	logic [COUNT_WIDTH-1:0] cnt_wdata;
	logic [SLOT_COUNT-1:0]  live_d;
	logic [LEN_W-1:0]       length_d;
	status_t                status_d;
	logic [VALUE_WIDTH-1:0] rval_d;
	logic [COUNT_WIDTH-1:0] cnt_out_d;
	logic                   in_range;

	rsa_ram #(
		.WIDTH(VALUE_WIDTH),
		.DEPTH(SLOT_COUNT)
	) u_value_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (wr_idx),
		.wdata (val_q),
		.raddr (slot_index),
		.rdata (val_rd)
	);

	rsa_ram #(
		.WIDTH(COUNT_WIDTH),
		.DEPTH(SLOT_COUNT)
	) u_count_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (wr_idx),
		.wdata (cnt_wdata),
		.raddr (slot_index),
		.rdata (cnt_rd)
	);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q  <= op_t'(opcode);
			idx_q <= slot_index;
			val_q <= store_value;
		end
		if (cmd.exec) begin
			status       <= status_d;
			granted_slot <= wr_idx;
			read_value   <= rval_d;
			live_length  <= length_d;
			slot_count   <= cnt_out_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q   <= '0;
			length_q <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= cmd.exec;
			if (cmd.exec) begin
				live_q   <= live_d;
				length_q <= length_d;
			end
		end
	end

	assign done = done_q;

	// A slot that is not live has a zero count, whatever its memory entry holds.
	assign cnt_cur  = live_q[idx_q] ? cnt_rd : '0;
	assign in_range = {1'b0, idx_q} < length_q;

	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			free_vec[i] = !live_q[i] && (LEN_W'(i) < length_q);
		end
		live_drop        = live_q;
		live_drop[idx_q] = 1'b0;
	end

	// Lowest free slot below the pool length.
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (free_vec[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	// Highest slot still live once the addressed slot is released.
	always_comb begin
		hi_found = 1'b0;
		hi_idx   = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (live_drop[i]) begin
				hi_found = 1'b1;
				hi_idx   = IDX_W'(i);
			end
		end
	end

	always_comb begin
		val_we    = 1'b0;
		cnt_we    = 1'b0;
		wr_idx    = idx_q;
		cnt_wdata = cnt_cur;
		live_d    = live_q;
		length_d  = length_q;
		status_d  = ST_OK;
		rval_d    = '0;
		cnt_out_d = '0;
		if (op_q == OP_ALLOC) begin
			if (free_found) begin
				wr_idx = free_idx;
			end else if (length_q == LEN_W'(SLOT_COUNT)) begin
				wr_idx   = '0;
				status_d = ST_FULL;
			end else begin
				wr_idx   = length_q[IDX_W-1:0];
				length_d = length_q + LEN_W'(1);
			end
			if (status_d == ST_OK) begin
				val_we         = cmd.exec;
				cnt_we         = cmd.exec;
				cnt_wdata      = CNT_ONE;
				live_d[wr_idx] = 1'b1;
				cnt_out_d      = CNT_ONE;
			end
		end else if (!in_range) begin
			status_d = ST_OOB;
		end else if (!live_q[idx_q]) begin
			status_d = ST_UAF;
		end else begin
			case (op_q)
				OP_READ: begin
					rval_d    = val_rd;
					cnt_out_d = cnt_cur;
				end
				OP_ADD: begin
					if (cnt_cur == CNT_MAX) begin
						status_d  = ST_OVF;
						cnt_out_d = cnt_cur;
					end else begin
						cnt_wdata = cnt_cur + CNT_ONE;
						cnt_we    = cmd.exec;
						cnt_out_d = cnt_wdata;
					end
				end
				OP_DROP: begin
					cnt_wdata = cnt_cur - CNT_ONE;
					cnt_we    = cmd.exec;
					cnt_out_d = cnt_wdata;
					if (cnt_cur == CNT_ONE) begin
						live_d   = live_drop;
						length_d = hi_found ? ({1'b0, hi_idx} + LEN_W'(1)) : '0;
					end
				end
				default: begin
					status_d = ST_OK;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* sim/refcounted_slot_allocator_tb.sv */
// ----------------------------------------------------------------------------
// refcounted_slot_allocator_tb
// Drives allocate, read, add-reference and drop-reference requests into the
// slot allocator, predicts each result from a local model of the counts, value
// words and pool length (lit plan rows give it typed in), and compares field by field.
// ----------------------------------------------------------------------------
module refcounted_slot_allocator_tb;
	import rsa_pkg::*;

	typedef struct packed {
		status_t                st;
		logic [IDX_W-1:0]       slot;
		logic [VALUE_WIDTH-1:0] val;
		logic [LEN_W-1:0]       len;
		logic [COUNT_WIDTH-1:0] cnt;
	} pool_result_t;

	typedef struct packed {
		op_t                    op;
		logic [IDX_W-1:0]       idx;
		logic [VALUE_WIDTH-1:0] val;
		logic [8:0]             reps;
		bit                     lit;
		pool_result_t           want;
	} step_t;

	typedef enum logic [1:0] {
		MIX_BALANCED,
		MIX_GROW,
		MIX_SHRINK,
		MIX_PUMP
	} mix_t;

	localparam int RANDOM_ITEMS = 300;

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic [1:0]             opcode;
	logic [IDX_W-1:0]       slot_index;
	logic [VALUE_WIDTH-1:0] store_value;
	logic                   done;
	status_t                status;
	logic [IDX_W-1:0]       granted_slot;
	logic [VALUE_WIDTH-1:0] read_value;
	logic [LEN_W-1:0]       live_length;
	logic [COUNT_WIDTH-1:0] slot_count;

	// Local copy of the pool.
	logic [VALUE_WIDTH-1:0] slot_vals [SLOT_COUNT];
	logic [COUNT_WIDTH-1:0] slot_refs [SLOT_COUNT] = '{default: '0};
	logic [LEN_W-1:0]       pool_len = '0;

	pool_result_t pending [$];
	int           mismatches = 0;
	bit           idle_on = 1'b1;
	bit           lit_row = 1'b0;
	pool_result_t lit_want = '0;

	// Directed requests. Rows with lit set carry the result typed in; the
	// others are checked against the prediction. Repeated rows add the
	// repeat number to the value word.
	step_t plan [25] = '{
		'{OP_READ,  6'd0,  64'd0, 9'd1, 1'b1, '{ST_OOB, 6'd0,  64'd0, 7'd0, 8'd0}},
		'{OP_ADD,   6'd63, 64'd0, 9'd1, 1'b1, '{ST_OOB, 6'd63, 64'd0, 7'd0, 8'd0}},
		'{OP_DROP,  6'd5,  64'd0, 9'd1, 1'b1, '{ST_OOB, 6'd5,  64'd0, 7'd0, 8'd0}},
		'{OP_ALLOC, 6'd0,  '1,    9'd1, 1'b1, '{ST_OK,  6'd0,  64'd0, 7'd1, 8'd1}},
		'{OP_ALLOC, 6'd63, 64'd0, 9'd1, 1'b1, '{ST_OK,  6'd1,  64'd0, 7'd2, 8'd1}},
		'{OP_ALLOC, 6'd0,  64'hA5A5_A5A5_A5A5_A5A5, 9'd1, 1'b1,
			'{ST_OK, 6'd2, 64'd0, 7'd3, 8'd1}},
		'{OP_READ,  6'd0,  64'd0, 9'd1, 1'b1, '{ST_OK,  6'd0,  '1,    7'd3, 8'd1}},
		'{OP_READ,  6'd1,  64'd0, 9'd1, 1'b1, '{ST_OK,  6'd1,  64'd0, 7'd3, 8'd1}},
		'{OP_ADD,   6'd1,  64'd0, 9'd1, 1'b0, '0},
		'{OP_DROP,  6'd1,  64'd0, 9'd1, 1'b0, '0},
		'{OP_DROP,  6'd1,  64'd0, 9'd1, 1'b0, '0},
		'{OP_READ,  6'd1,  64'd0, 9'd1, 1'b1, '{ST_UAF, 6'd1,  64'd0, 7'd3, 8'd0}},
		'{OP_ADD,   6'd1,  64'd0, 9'd1, 1'b1, '{ST_UAF, 6'd1,  64'd0, 7'd3, 8'd0}},
		'{OP_DROP,  6'd1,  64'd0, 9'd1, 1'b1, '{ST_UAF, 6'd1,  64'd0, 7'd3, 8'd0}},
		'{OP_ALLOC, 6'd0,  64'h5A5A_5A5A_5A5A_5A5A, 9'd1, 1'b0, '0},
		'{OP_DROP,  6'd2,  64'd0, 9'd1, 1'b0, '0},
		'{OP_READ,  6'd2,  64'd0, 9'd1, 1'b1, '{ST_OOB, 6'd2,  64'd0, 7'd2, 8'd0}},
		'{OP_ADD,   6'd0,  64'd0, 9'd254, 1'b0, '0},
		'{OP_ADD,   6'd0,  64'd0, 9'd1, 1'b1, '{ST_OVF, 6'd0,  64'd0, 7'd2, 8'd255}},
		'{OP_READ,  6'd0,  64'd0, 9'd1, 1'b1, '{ST_OK,  6'd0,  '1,    7'd2, 8'd255}},
		'{OP_DROP,  6'd0,  64'd0, 9'd255, 1'b0, '0},
		'{OP_ALLOC, 6'd0,  64'h100, 9'd63, 1'b0, '0},
		'{OP_ALLOC, 6'd0,  '1,    9'd1, 1'b1, '{ST_FULL, 6'd0, 64'd0, 7'd64, 8'd0}},
		'{OP_DROP,  6'd63, 64'd0, 9'd1, 1'b0, '0},
		'{OP_READ,  6'd63, 64'd0, 9'd1, 1'b1, '{ST_OOB, 6'd63, 64'd0, 7'd63, 8'd0}}
	};

	refcounted_slot_allocator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.slot_index   (slot_index),
		.store_value  (store_value),
		.done         (done),
		.status       (status),
		.granted_slot (granted_slot),
		.read_value   (read_value),
		.live_length  (live_length),
		.slot_count   (slot_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#500000;
		$display("Some tests failed");
		$finish;
	end

	// Applies one request to the local pool and returns the result it gives.
	function automatic pool_result_t apply_request(op_t op, logic [IDX_W-1:0] idx,
			logic [VALUE_WIDTH-1:0] val);
		pool_result_t r;
		int           free_at;
		int           n;
		r = '{ST_OK, idx, '0, '0, '0};
		if (op == OP_ALLOC) begin
			free_at = -1;
			for (int i = 0; i < pool_len; i++) begin
				if (free_at < 0 && slot_refs[i] == '0)
					free_at = i;
			end
			if (free_at < 0) begin
				if (pool_len == SLOT_COUNT) begin
					r.st   = ST_FULL;
					r.slot = '0;
					r.len  = pool_len;
					return r;
				end
				free_at  = pool_len;
				pool_len = pool_len + 1'b1;
			end
			slot_vals[free_at] = val;
			slot_refs[free_at] = CNT_ONE;
			r.slot             = IDX_W'(free_at);
			r.cnt              = CNT_ONE;
		end else if (idx >= pool_len) begin
			r.st = ST_OOB;
		end else if (slot_refs[idx] == '0) begin
			r.st = ST_UAF;
		end else begin
			case (op)
				OP_READ: begin
					r.val = slot_vals[idx];
					r.cnt = slot_refs[idx];
				end
				OP_ADD: begin
					if (slot_refs[idx] == CNT_MAX) begin
						r.st = ST_OVF;
					end else begin
						slot_refs[idx] = slot_refs[idx] + 1'b1;
					end
					r.cnt = slot_refs[idx];
				end
				default: begin
					slot_refs[idx] = slot_refs[idx] - 1'b1;
					// The pool ends just past the highest slot still in use.
					if (slot_refs[idx] == '0) begin
						n = pool_len;
						while (n > 0 && slot_refs[n-1] == '0)
							n--;
						pool_len = LEN_W'(n);
					end
					r.cnt = slot_refs[idx];
				end
			endcase
		end
		r.len = pool_len;
		return r;
	endfunction

	task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch in %s: expected %0h, got %0h", what, want, got);
	endtask

	always @(posedge clk) begin : result_check
		pool_result_t got;
		pool_result_t want;
		if (arst_n) begin
			if (done) begin
				got.st   = status;
				got.slot = granted_slot;
				got.val  = read_value;
				got.len  = live_length;
				got.cnt  = slot_count;
				if (pending.size() == 0) begin
					note_mismatch("result with no request pending, slot", '0, got.slot);
				end else begin
					want = pending.pop_front();
					if (got.st !== want.st)
						note_mismatch("status", want.st, got.st);
					if (got.slot !== want.slot)
						note_mismatch("granted_slot", want.slot, got.slot);
					if (got.val !== want.val)
						note_mismatch("read_value", want.val, got.val);
					if (got.len !== want.len)
						note_mismatch("live_length", want.len, got.len);
					if (got.cnt !== want.cnt)
						note_mismatch("slot_count", want.cnt, got.cnt);
				end
			end
			if (start && !busy) begin
				want = apply_request(op_t'(opcode), slot_index, store_value);
				if (lit_row)
					want = lit_want;
				pending = {pending, want};
			end
		end
	end

	// Presents one request from a falling edge, after random idle gaps while idle_on is set, and holds it until taken.
	task automatic issue(op_t op, logic [IDX_W-1:0] idx, logic [VALUE_WIDTH-1:0] val,
			bit lit, pool_result_t want);
		@(negedge clk);
		while (idle_on && $urandom_range(99) < 23) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start       <= 1'b1;
		opcode      <= op;
		slot_index  <= idx;
		store_value <= val;
		lit_row     <= lit;
		lit_want    <= want;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		mix_t             mode;
		int               seg_len;
		int               issued;
		int               r;
		int               t_alloc;
		int               t_read;
		int               t_add;
		int               live [$];
		op_t              op;
		logic [IDX_W-1:0] idx;

		arst_n      = 1'b0;
		start       = 1'b0;
		opcode      = OP_ALLOC;
		slot_index  = '0;
		store_value = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int n = 0; n < 25; n++) begin
			for (int k = 0; k < plan[n].reps; k++)
				issue(plan[n].op, plan[n].idx, plan[n].val + k, plan[n].lit, plan[n].want);
		end
		drain();

		issued = 0;
		while (issued < RANDOM_ITEMS) begin
			mode    = mix_t'($urandom_range(3));
			seg_len = (mode == MIX_PUMP) ? $urandom_range(100, 300) : $urandom_range(40, 120);
			case (mode)
				MIX_GROW: begin
					t_alloc = 60; t_read = 75; t_add = 85;
				end
				MIX_SHRINK: begin
					t_alloc = 10; t_read = 25; t_add = 35;
				end
				MIX_PUMP: begin
					t_alloc = 0; t_read = 10; t_add = 95;
				end
				default: begin
					t_alloc = 30; t_read = 55; t_add = 75;
				end
			endcase
			for (int k = 0; k < seg_len && issued < RANDOM_ITEMS; k++) begin
				// A long stretch runs back to back with no gaps from the sender.
				idle_on = !(issued >= 100 && issued < 220);
				live.delete();
				for (int i = 0; i < pool_len; i++) begin
					if (slot_refs[i] != '0)
						live = {live, i};
				end
				r = $urandom_range(99);
				if (r < t_alloc)
					op = OP_ALLOC;
				else if (r < t_read)
					op = OP_READ;
				else if (r < t_add)
					op = OP_ADD;
				else
					op = OP_DROP;
				// Mostly live slots; some freed slots and some past the end.
				r = $urandom_range(99);
				if (mode == MIX_PUMP && live.size() > 0 && r < 85)
					idx = IDX_W'(live[0]);
				else if (live.size() > 0 && r < 80)
					idx = IDX_W'(live[$urandom_range(live.size() - 1)]);
				else if (pool_len > 0 && r < 92)
					idx = IDX_W'($urandom_range(pool_len - 1));
				else
					idx = IDX_W'($urandom_range(SLOT_COUNT - 1));
				issue(op, idx, {$urandom, $urandom}, 1'b0, '0);
				issued++;
			end
			if ($urandom_range(1) == 1)
				drain();
		end

		@(negedge clk);
		start <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
